// ===== hw/rtl/lcsd_pkg.sv =====
// Shared widths, reset values and the ring control type of the light change start detector.
package lcsd_pkg;

   localparam int unsigned SAMPLE_W       = 12;
   localparam int unsigned AVG_W          = 13;
   localparam int unsigned THRESH_W       = 12;
   localparam int unsigned WINDOW_DEFAULT = 10;
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(100);
   localparam logic [AVG_W-1:0]    AVG_MAX      = {AVG_W{1'b1}};

   typedef struct packed {
      logic                fill;
      logic                write;
      logic [SAMPLE_W-1:0] data;
   } ring_ctrl_type;

endpackage

// ===== hw/rtl/light_change_start_detector_core.sv =====
// Light change start detector: input register, per-beat update and result register.
//
// One req beat carries a light sample in req_tdata and the enable switch level in
// req_tuser. Each beat yields exactly one rsp beat: running average in rsp_tdata,
// start pulse and armed flag in rsp_tuser. Switch off disarms and clears the average
// and ring position; the first enabled beat fills the ring and arms. A deviation from
// the updated average above the threshold raises start and disarms.
// Path: a taken beat passes the input register, then the single-pass update into the
// result register, which also updates the state.
// Throughput: one beat per cycle while rsp_tready keeps up; the state update is
// combinational via the ring read, both constant divisions, the add and the compare.
// Stall: a waiting rsp beat holds; one more beat is taken into the input register,
// then req_tready drops until rsp_tready frees the result register.
// Reset: disarmed, average and position zero, threshold 100, both registers empty.
// csr_wr_en writes the threshold at once; write only while the block is idle.
module light_change_start_detector_core #(
   parameter int unsigned WINDOW = lcsd_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // [11:0] light_sample
   input  logic                          req_tuser,   // [0] switch_on
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // [12:0] running_average
   output logic [1:0]                    rsp_tuser,   // [0] start_detected, [1] armed
   input  logic                          csr_wr_en,
   input  logic [lcsd_pkg::THRESH_W-1:0] csr_wr_data
);

   localparam int unsigned POS_W = $clog2(WINDOW);

   logic                          in_valid_ff, in_valid_in;
   logic [lcsd_pkg::SAMPLE_W-1:0] in_sample_ff;
   logic                          in_switch_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [lcsd_pkg::AVG_W-1:0]    out_avg_ff;
   logic                          out_start_ff;
   logic                          out_armed_ff;
   logic [lcsd_pkg::THRESH_W-1:0] thresh_ff;
   logic                          active_ff, active_in;
   logic [lcsd_pkg::AVG_W-1:0]    avg_ff, avg_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [POS_W-1:0]              rd_addr;
   logic [lcsd_pkg::SAMPLE_W-1:0] oldest;
   lcsd_pkg::ring_ctrl_type       ring_ctrl;
   lcsd_pkg::ring_ctrl_type       ring_wr;
   logic                          start;
   logic                          advance;
   logic                          take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         thresh_ff    <= lcsd_pkg::THRESH_RESET;
         active_ff    <= 1'b0;
         avg_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (advance) begin
            active_ff <= active_in;
            avg_ff    <= avg_in;
            pos_ff    <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_sample_ff <= req_tdata[lcsd_pkg::SAMPLE_W-1:0];
         in_switch_ff <= req_tuser;
      end
      if (advance) begin
         out_avg_ff   <= avg_in;
         out_start_ff <= start;
         out_armed_ff <= active_in;
      end
   end

   lcsd_calc #(
      .WINDOW (WINDOW),
      .POS_W  (POS_W)
   ) u_calc (
      .switch_on (in_switch_ff),
      .sample    (in_sample_ff),
      .threshold (thresh_ff),
      .active    (active_ff),
      .avg       (avg_ff),
      .pos       (pos_ff),
      .oldest    (oldest),
      .rd_addr   (rd_addr),
      .ring_ctrl (ring_ctrl),
      .active_in (active_in),
      .avg_in    (avg_in),
      .pos_in    (pos_in),
      .start     (start)
   );

   always_comb begin
      ring_wr       = ring_ctrl;
      ring_wr.fill  = ring_ctrl.fill && advance;
      ring_wr.write = ring_ctrl.write && advance;
   end

   lcsd_ring #(
      .WINDOW (WINDOW),
      .POS_W  (POS_W)
   ) u_ring (
      .clock   (clock),
      .ctrl    (ring_wr),
      .addr    (rd_addr),
      .rd_data (oldest)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(16 - lcsd_pkg::AVG_W)'(0), out_avg_ff};
   assign rsp_tuser  = {out_armed_ff, out_start_ff};

endmodule

// ===== hw/rtl/lcsd_ring.sv =====
// Sample ring: parallel fill on arming, single-entry write and read at the ring position.
module lcsd_ring #(
   parameter int unsigned WINDOW = lcsd_pkg::WINDOW_DEFAULT,
   parameter int unsigned POS_W  = $clog2(WINDOW)
) (
   input  logic                          clock,
   input  lcsd_pkg::ring_ctrl_type       ctrl,
   input  logic [POS_W-1:0]              addr,
   output logic [lcsd_pkg::SAMPLE_W-1:0] rd_data
);

   logic [lcsd_pkg::SAMPLE_W-1:0] ring_ff [WINDOW];

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW; i++) begin
         if (ctrl.fill || (ctrl.write && (addr == POS_W'(i)))) begin
            ring_ff[i] <= ctrl.data;
         end
      end
   end

   assign rd_data = ring_ff[addr];

endmodule

// ===== hw/rtl/lcsd_calc.sv =====
// Per-beat update: arming, running average, deviation compare and ring position step.
module lcsd_calc #(
   parameter int unsigned WINDOW = lcsd_pkg::WINDOW_DEFAULT,
   parameter int unsigned POS_W  = $clog2(WINDOW)
) (
   input  logic                          switch_on,
   input  logic [lcsd_pkg::SAMPLE_W-1:0] sample,
   input  logic [lcsd_pkg::THRESH_W-1:0] threshold,
   input  logic                          active,
   input  logic [lcsd_pkg::AVG_W-1:0]    avg,
   input  logic [POS_W-1:0]              pos,
   input  logic [lcsd_pkg::SAMPLE_W-1:0] oldest,
   output logic [POS_W-1:0]              rd_addr,
   output lcsd_pkg::ring_ctrl_type       ring_ctrl,
   output logic                          active_in,
   output logic [lcsd_pkg::AVG_W-1:0]    avg_in,
   output logic [POS_W-1:0]              pos_in,
   output logic                          start
);

   localparam int unsigned SUM_W = lcsd_pkg::AVG_W + 2;
   localparam int unsigned DIF_W = lcsd_pkg::AVG_W + 1;
   // floor(x / WINDOW) as (x * DIV_M) >> DIV_SH, exact for every 12-bit sample
   localparam int unsigned DIV_SH = lcsd_pkg::SAMPLE_W + $clog2(WINDOW);
   localparam int unsigned DIV_M  = ((1 << DIV_SH) + WINDOW - 1) / WINDOW;
   localparam int unsigned MUL_W  = 2 * lcsd_pkg::SAMPLE_W + 2;

   logic [MUL_W-1:0]              old_prod;
   logic [MUL_W-1:0]              new_prod;
   logic [lcsd_pkg::SAMPLE_W-1:0] old_div;
   logic [lcsd_pkg::SAMPLE_W-1:0] new_div;
   logic signed [SUM_W-1:0]       sum;
   logic [lcsd_pkg::AVG_W-1:0]    avg_upd;
   logic signed [DIF_W-1:0]       diff;
   logic [lcsd_pkg::AVG_W-1:0]    dev;
   logic                          over;

   assign rd_addr = (pos >= POS_W'(WINDOW - 1) && pos != POS_W'(WINDOW - 1)) ? '0 : pos;
   assign old_prod = MUL_W'(oldest) * MUL_W'(DIV_M);
   assign new_prod = MUL_W'(sample) * MUL_W'(DIV_M);
   assign old_div  = lcsd_pkg::SAMPLE_W'(old_prod >> DIV_SH);
   assign new_div  = lcsd_pkg::SAMPLE_W'(new_prod >> DIV_SH);
   assign sum = $signed({2'b00, avg}) - $signed(SUM_W'(old_div)) + $signed(SUM_W'(new_div));

   always_comb begin
      if (sum < 0) begin
         avg_upd = '0;
      end else if (sum > $signed({2'b00, lcsd_pkg::AVG_MAX})) begin
         avg_upd = lcsd_pkg::AVG_MAX;
      end else begin
         avg_upd = sum[lcsd_pkg::AVG_W-1:0];
      end
   end

   assign diff = $signed(DIF_W'(sample)) - $signed({1'b0, avg_upd});
   assign dev  = diff[DIF_W-1] ? lcsd_pkg::AVG_W'(-diff) : diff[lcsd_pkg::AVG_W-1:0];
   assign over = dev > lcsd_pkg::AVG_W'(threshold);

   always_comb begin
      ring_ctrl.fill  = 1'b0;
      ring_ctrl.write = 1'b0;
      ring_ctrl.data  = sample;
      active_in       = active;
      avg_in          = avg;
      pos_in          = pos;
      start           = 1'b0;
      if (!switch_on) begin
         active_in = 1'b0;
         avg_in    = '0;
         pos_in    = '0;
      end else if (!active) begin
         ring_ctrl.fill = 1'b1;
         active_in      = 1'b1;
         avg_in         = lcsd_pkg::AVG_W'(sample);
      end else begin
         ring_ctrl.write = 1'b1;
         avg_in          = avg_upd;
         pos_in          = (rd_addr == POS_W'(WINDOW - 1)) ? '0 : rd_addr + POS_W'(1);
         start           = over;
         active_in       = !over;
      end
   end

endmodule
